>>> hw/rtl/header_footer_frame_receiver_defines.svh
// Assertion macros for the header/footer frame receiver.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HEADER_FOOTER_FRAME_RECEIVER_DEFINES_SVH
`define HEADER_FOOTER_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HFR_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("hfr assertion failed");

// next-cycle implication, disabled in reset
`define HFR_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("hfr assertion failed");

`endif

>>> hw/rtl/hfr_pkg.sv
// Types, constants and helpers for the header/footer frame receiver.
// No dependencies; imported by every module of the block.
package hfr_pkg;

  localparam int FRAME_BYTES   = 6;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
  localparam int KEPT_BYTES    = (PAYLOAD_BYTES < 4) ? PAYLOAD_BYTES : 4;
  localparam int KEPT_BITS     = 8 * KEPT_BYTES;
  localparam int POS_W         = 4;
  localparam int PHASE_W       = 2;
  localparam int CFG_IDX_W     = 1;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] HEADER_RESET = 8'hAA;
  localparam logic [7:0] FOOTER_RESET = 8'h55;

  localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RECV = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOOTER = 1'd1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       overrun_event;
  } in_item_t;

  typedef struct packed {
    logic               frame_done;
    logic signed [31:0] position_x;
    logic [31:0]        good_frames;
    logic [31:0]        bad_events;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        good_count;
    logic [31:0]        bad_count;
  } core_status_t;

  // sign-extend the gathered payload from the top bit of its last kept byte
  function automatic logic signed [31:0] payload_value(input logic [31:0] shift);
    logic signed [31:0] v;
    for (int i = 0; i < 32; i++) begin
      v[i] = (i < KEPT_BITS) ? shift[i] : shift[KEPT_BITS-1];
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/hfr_in_stage.sv
// Input register of the frame receiver: holds one item for the core.
// Depends on hfr_pkg.
module hfr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hfr_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output hfr_pkg::in_item_t item
);
  import hfr_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_stall   = valid_r && !advance;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    priority if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hw/rtl/hfr_frame_core.sv
// Frame state, configuration registers and per-byte next-state logic.
// Depends on hfr_pkg.
module hfr_frame_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_wdata,
  input  logic                              step,
  input  hfr_pkg::in_item_t                 item,
  output hfr_pkg::out_item_t                res,
  output hfr_pkg::core_status_t             status
);
  import hfr_pkg::*;

  logic [7:0]         header_r, footer_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [31:0]        shift_r, shift_nxt;
  logic [31:0]        held_r, held_nxt;
  logic [31:0]        good_r, good_nxt;
  logic [31:0]        bad_r, bad_nxt;
  logic               done;
  logic               is_header, is_footer;

  assign is_header = (item.rx_byte == header_r);
  assign is_footer = (item.rx_byte == footer_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    done      = 1'b0;
    if (item.overrun_event) begin
      bad_nxt   = bad_r + 32'd1;
      pos_nxt   = '0;
      phase_nxt = PH_HUNT;
    end else begin
      unique case (phase_r)
        PH_HUNT, PH_DONE: begin
          if (is_header) begin
            shift_nxt = '0;
            pos_nxt   = POS_W'(1);
            phase_nxt = PH_RECV;
          end else begin
            pos_nxt   = '0;
            phase_nxt = PH_HUNT;
          end
        end
        PH_RECV: begin
          if (pos_r >= LAST_POS) begin
            priority if (is_footer) begin
              held_nxt  = payload_value(shift_r);
              good_nxt  = good_r + 32'd1;
              done      = 1'b1;
              phase_nxt = PH_DONE;
              pos_nxt   = '0;
            end else if (is_header) begin
              bad_nxt   = bad_r + 32'd1;
              shift_nxt = '0;
              pos_nxt   = POS_W'(1);
              phase_nxt = PH_RECV;
            end else begin
              bad_nxt   = bad_r + 32'd1;
              pos_nxt   = '0;
              phase_nxt = PH_HUNT;
            end
          end else begin
            for (int m = 0; m < KEPT_BYTES; m++) begin
              if (pos_r == POS_W'(m + 1)) begin
                shift_nxt[8*m +: 8] = item.rx_byte;
              end
            end
            pos_nxt = pos_r + POS_W'(1);
          end
        end
        default: begin
          pos_nxt   = '0;
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  assign res.frame_done  = done;
  assign res.position_x  = held_nxt;
  assign res.good_frames = good_nxt;
  assign res.bad_events  = bad_nxt;

  assign status.good_count = good_r;
  assign status.bad_count  = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      footer_r <= FOOTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_FOOTER: footer_r <= cfg_wdata;
        default:    header_r <= header_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      shift_r <= '0;
      held_r  <= '0;
      good_r  <= '0;
      bad_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      held_r  <= held_nxt;
      good_r  <= good_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

>>> hw/rtl/hfr_out_stage.sv
// Result register of the frame receiver: holds one item until taken.
// Depends on hfr_pkg.
module hfr_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  hfr_pkg::out_item_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output hfr_pkg::out_item_t out_item
);
  import hfr_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    priority if (step) begin
      valid_nxt = 1'b1;
    end else if (free) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      item_r <= res;
    end
  end

endmodule

>>> hw/rtl/header_footer_frame_receiver.sv
// Header/footer frame receiver: one result item for every byte item taken in.
// A byte is accepted every cycle when the result side keeps up; each item is held in
// the input register and moves into the result register once the result side is free.
// A stall on the result side reaches in_stall in the same cycle once the input and
// result registers are both full.
// Depends on hfr_pkg, hfr_in_stage, hfr_frame_core, hfr_out_stage and the defines.
`include "header_footer_frame_receiver_defines.svh"

module header_footer_frame_receiver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hfr_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hfr_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [hfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata
);
  import hfr_pkg::*;

  logic         item_valid;
  in_item_t     item;
  logic         free;
  logic         step;
  out_item_t    res;
  core_status_t status;

  assign step = item_valid && free;

  hfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  hfr_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res       (res),
    .status    (status)
  );

  hfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  `HFR_ASSERT_NOW(a_good_step, step, res.good_frames == status.good_count + 32'(res.frame_done))
  `HFR_ASSERT_NOW(a_overrun, step && item.overrun_event, !res.frame_done && res.bad_events == status.bad_count + 32'd1)
  `HFR_ASSERT_NEXT(a_result_lands, step, out_valid)
  `HFR_ASSERT_NEXT(a_counts_hold, !step, $stable(status.good_count) && $stable(status.bad_count))

endmodule

>>> tb/frame_result_checker.sv
// Checker for the header/footer frame receiver: watches the byte, result and register ports,
// predicts one result item per accepted byte and compares it field by field.
// Depends on hfr_pkg for the item types, phase codes and register indexes.
module frame_result_checker
  import hfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  output int unsigned          mismatches,
  output int unsigned          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]         header_byte;
  logic [7:0]         footer_byte;
  logic [PHASE_W-1:0] rx_phase;
  logic [POS_W-1:0]   rx_pos;
  logic [31:0]        gathered;
  logic [31:0]        held_x;
  logic [31:0]        good_total;
  logic [31:0]        bad_total;
  int unsigned        fail_total = 0;
  out_item_t          pending_results[$];

  function automatic logic [31:0] extend_payload(input logic [31:0] raw);
    int n;
    n = FRAME_BYTES - 2;
    if (n >= 4) return raw;
    return 32'($signed(raw << (32 - 8 * n)) >>> (32 - 8 * n));
  endfunction

  task automatic open_frame();
    gathered = '0;
    rx_pos   = POS_W'(1);
    rx_phase = PH_RECV;
  endtask

  task automatic take_byte(input in_item_t it, output out_item_t res);
    int   pos;
    logic done;
    done = 1'b0;
    if (it.overrun_event) begin
      bad_total = bad_total + 1;
      rx_pos    = '0;
      rx_phase  = PH_HUNT;
    end else begin
      if (rx_phase == PH_DONE) begin
        rx_phase = PH_HUNT;
        rx_pos   = '0;
      end
      if (rx_phase == PH_HUNT) begin
        if (it.rx_byte == header_byte) open_frame();
      end else if (rx_phase == PH_RECV) begin
        pos = int'(rx_pos);
        if (pos < FRAME_BYTES) begin
          if (pos >= 1 && pos < FRAME_BYTES - 1 && pos - 1 < 4)
            gathered[8 * (pos - 1) +: 8] = it.rx_byte;
          pos++;
          rx_pos = POS_W'(pos);
        end
        if (pos >= FRAME_BYTES) begin
          if (it.rx_byte == footer_byte) begin
            held_x     = extend_payload(gathered);
            good_total = good_total + 1;
            done       = 1'b1;
            rx_phase   = PH_DONE;
            rx_pos     = '0;
          end else if (it.rx_byte == header_byte) begin
            bad_total = bad_total + 1;
            open_frame();
          end else begin
            bad_total = bad_total + 1;
            rx_pos    = '0;
            rx_phase  = PH_HUNT;
          end
        end
      end else begin
        rx_pos   = '0;
        rx_phase = PH_HUNT;
      end
    end
    res.frame_done  = done;
    res.position_x  = held_x;
    res.good_frames = good_total;
    res.bad_events  = bad_total;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      header_byte = HEADER_RESET;
      footer_byte = FOOTER_RESET;
      rx_phase    = PH_HUNT;
      rx_pos      = '0;
      gathered    = '0;
      held_x      = '0;
      good_total  = '0;
      bad_total   = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEADER: header_byte = cfg_wdata;
          CFG_FOOTER: footer_byte = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        take_byte(in_item, want);
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item with no byte item waiting for it");
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          if (out_item.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, out_item.frame_done);
            fail_total++;
          end
          if (out_item.position_x !== want.position_x) begin
            $error("position_x: expected %0d, got %0d", want.position_x, out_item.position_x);
            fail_total++;
          end
          if (out_item.good_frames !== want.good_frames) begin
            $error("good_frames: expected %0d, got %0d", want.good_frames,
                   out_item.good_frames);
            fail_total++;
          end
          if (out_item.bad_events !== want.bad_events) begin
            $error("bad_events: expected %0d, got %0d", want.bad_events, out_item.bad_events);
            fail_total++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
    mismatches  <= fail_total;
  end

endmodule

>>> tb/header_footer_frame_receiver_tb.sv
// Top of the header/footer frame receiver testbench: clock, reset, byte and register stimulus,
// result-side stalls, watchdog and verdict.
// Depends on hfr_pkg, the receiver RTL and frame_result_checker.
module header_footer_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned outstanding;

  logic [7:0]  header_now = HEADER_RESET;
  logic [7:0]  footer_now = FOOTER_RESET;
  int          burst_left = 0;
  int          gap_max    = 0;
  int          sent       = 0;
  int          stall_style = 0;
  int          stall_timer = 0;
  int unsigned stall_tick  = 0;
  int unsigned idle_cycles = 0;

  logic [8:0] opening_bytes [$] = '{
    9'h0AA, 9'h000, 9'h000, 9'h000, 9'h080, 9'h055,
    9'h0AA, 9'h001, 9'h002, 9'h003, 9'h004, 9'h0AA,
    9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h055,
    9'h0AA, 9'h012, 9'h1FF,
    9'h0AA, 9'h011, 9'h022, 9'h033, 9'h044, 9'h000
  };

  always #4 clk = ~clk;

  header_footer_frame_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_timer == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 300);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= (stall_tick[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic ovr);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_item  <= '{rx_byte: b, overrun_event: ovr};
    do @(posedge clk); while (in_stall);
    burst_left--;
    sent++;
  endtask

  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reconfigure(input logic [7:0] hdr, input logic [7:0] ftr);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_wdata <= hdr;
    @(posedge clk);
    cfg_index <= CFG_FOOTER;
    cfg_wdata <= ftr;
    @(posedge clk);
    cfg_we     <= 1'b0;
    header_now = hdr;
    footer_now = ftr;
  endtask

  task automatic send_frame();
    int         kind;
    int         cut;
    logic [7:0] data;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      return;
    end
    if (kind < 12) begin
      push_byte(8'($urandom), 1'b1);
      return;
    end
    cut = (kind < 20) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    push_byte(header_now, 1'b0);
    for (int k = 1; k < FRAME_BYTES - 1 && k < cut; k++) begin
      case ($urandom_range(0, 7))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        2:       data = 8'h80;
        3:       data = 8'h7F;
        default: data = 8'($urandom);
      endcase
      push_byte(data, 1'b0);
    end
    if (cut < FRAME_BYTES) begin
      push_byte(8'($urandom), 1'b1);
      return;
    end
    if (kind < 70)      data = footer_now;
    else if (kind < 82) data = header_now;
    else                data = 8'($urandom);
    push_byte(data, 1'b0);
  endtask

  initial begin
    logic [7:0] pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening_bytes[i]) push_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    for (int ph = 0; ph < 8; ph++) begin
      pick = 8'($urandom);
      case (ph)
        0: ;
        1: reconfigure(8'h00, 8'hFF);
        2: reconfigure(8'hFF, 8'h00);
        3: reconfigure(8'h5A, 8'h5A);
        4: reconfigure(pick, 8'($urandom));
        5: reconfigure(HEADER_RESET, FOOTER_RESET);
        6: reconfigure(pick, pick);
        default: reconfigure(pick, ~pick);
      endcase
      gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 12);
      while (sent < 26 + (ph + 1) * 235) send_frame();
    end
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
